@@ src/assert_macros.svh @@
// Assertion macros used by the equalizer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising clk edge outside reset.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ src/cbq_eq_pkg.sv @@
// Shared types and constants of the cascaded biquad equalizer.
package cbq_eq_pkg;

    // Coefficient slots within one band
    localparam int SLOTS = 5;
    localparam logic [2:0] SLOT_B0 = 3'd0;
    localparam logic [2:0] SLOT_B1 = 3'd1;
    localparam logic [2:0] SLOT_B2 = 3'd2;
    localparam logic [2:0] SLOT_A1 = 3'd3;
    localparam logic [2:0] SLOT_A2 = 3'd4;

    // Item commands
    localparam logic CMD_FILTER    = 1'b0;
    localparam logic CMD_COEF_WRITE = 1'b1;

    // Fixed-point layout
    localparam int GUARD_BITS = 8;
    localparam int DELAY_BITS = 40;
    localparam logic [4:0] BAND_COUNT_RESET = 5'd10;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    // Steps of one band on the shared multiplier
    typedef enum logic [2:0] {
        STEP_READ,
        STEP_MUL_B0,
        STEP_Y,
        STEP_Z1A,
        STEP_Z2A,
        STEP_Z1B,
        STEP_WRITE
    } step_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic  accept_sample;
        logic  coef_write;
        logic  band_active;
        step_t step;
        logic  load_out;
    } cmd_t;

endpackage

@@ src/cascaded_biquad_equalizer.sv @@
// Top level of the multi-channel cascaded biquad equalizer.
// A sample request passes through the first band_count bands (capped at MAX_BANDS), each a
// transposed direct form II biquad with its own delay pair per channel; the result is the
// saturated sample with a clip flag. A coefficient-write request loads one word of the
// coefficient memory and gives no result. Coefficients reset to passthrough and
// delays to zero at once through per-entry valid bits, so no clearing pass is needed.
// Each band takes seven steps on the single shared coefficient multiplier, which computes the
// five products of the band one after another behind the registered coefficient and delay
// memory reads. Samples are processed one at a time; a new request is taken while the previous
// result still waits in the output register.
`include "assert_macros.svh"

module cascaded_biquad_equalizer #(
    parameter int MAX_BANDS      = 16,
    parameter int MAX_CHANNELS   = 8,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 26
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [2:0]                    channel,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic [3:0]                    coef_band,
    input  logic [2:0]                    coef_slot,
    input  logic signed [31:0]            coef_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic [2:0]                    channel_out,
    output logic                          clipped,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [4:0]                    cfg_data
);

    localparam int BI_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;

    cbq_eq_pkg::cmd_t cmd;
    logic [BI_W-1:0]  band;

    // Sequencer
    cbq_eq_ctrl #(
        .MAX_BANDS (MAX_BANDS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .band      (band)
    );

    // Arithmetic and storage
    cbq_eq_dp #(
        .MAX_BANDS      (MAX_BANDS),
        .MAX_CHANNELS   (MAX_CHANNELS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .band        (band),
        .channel     (channel),
        .sample_in   (sample_in),
        .coef_band   (coef_band),
        .coef_slot   (coef_slot),
        .coef_value  (coef_value),
        .sample_out  (sample_out),
        .channel_out (channel_out),
        .clipped     (clipped)
    );

    // Checks
    `ASSERT_IMP(a_write_not_in_band, cmd.coef_write, !cmd.band_active)
    `ASSERT_IMP(a_load_not_in_band, cmd.load_out, !cmd.band_active)
    `ASSERT_IMP(a_band_stalls_input, cmd.band_active, in_stall)
    `ASSERT_NXT(a_sample_goes_busy, cmd.accept_sample, in_stall)

endmodule

@@ src/cbq_eq_ctrl.sv @@
// Controller of the equalizer: handshakes, band sequencing, band count register.
module cbq_eq_ctrl #(
    parameter int MAX_BANDS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    output logic                                out_valid,
    input  logic                                out_stall,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [4:0]                          cfg_data,
    output cbq_eq_pkg::cmd_t                    cmd,
    output logic [((MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1)-1:0] band
);

    localparam int BI_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int BC_W = $clog2(MAX_BANDS + 1);

    cbq_eq_pkg::state_t state_reg, state_next;
    cbq_eq_pkg::step_t  step_reg, step_next;
    logic [BC_W-1:0]    band_reg, band_next;
    logic               out_valid_reg, out_valid_next;
    logic [4:0]         band_count_reg;
    logic [BC_W-1:0]    limit;
    logic               accept;

    // Band count register, written only while idle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            band_count_reg <= cbq_eq_pkg::BAND_COUNT_RESET;
        else if (cfg_valid && cfg_ready)
            band_count_reg <= cfg_data;
    end

    // No sample in flight and none arriving
    assign cfg_ready = (state_reg == cbq_eq_pkg::ST_IDLE) && !in_valid;

    // Counts above the band total act as the band total
    assign limit = (6'(band_count_reg) > 6'(MAX_BANDS)) ? BC_W'(MAX_BANDS)
                                                        : BC_W'(band_count_reg);

    assign in_stall  = (state_reg != cbq_eq_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign band      = band_reg[BI_W-1:0];

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cbq_eq_pkg::ST_IDLE;
            step_reg      <= cbq_eq_pkg::STEP_READ;
            band_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            band_reg      <= band_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        band_next         = band_reg;
        cmd.accept_sample = 1'b0;
        cmd.coef_write    = 1'b0;
        cmd.band_active   = 1'b0;
        cmd.step          = step_reg;
        cmd.load_out      = 1'b0;

        unique case (state_reg)
            cbq_eq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == cbq_eq_pkg::CMD_COEF_WRITE)
                        cmd.coef_write = 1'b1;
                    else
                    begin
                        cmd.accept_sample = 1'b1;
                        step_next         = cbq_eq_pkg::STEP_READ;
                        band_next         = '0;
                        state_next        = (limit == '0) ? cbq_eq_pkg::ST_FINISH
                                                          : cbq_eq_pkg::ST_RUN;
                    end
                end
            end
            cbq_eq_pkg::ST_RUN:
            begin
                cmd.band_active = 1'b1;
                unique case (step_reg)
                    cbq_eq_pkg::STEP_READ:   step_next = cbq_eq_pkg::STEP_MUL_B0;
                    cbq_eq_pkg::STEP_MUL_B0: step_next = cbq_eq_pkg::STEP_Y;
                    cbq_eq_pkg::STEP_Y:      step_next = cbq_eq_pkg::STEP_Z1A;
                    cbq_eq_pkg::STEP_Z1A:    step_next = cbq_eq_pkg::STEP_Z2A;
                    cbq_eq_pkg::STEP_Z2A:    step_next = cbq_eq_pkg::STEP_Z1B;
                    cbq_eq_pkg::STEP_Z1B:    step_next = cbq_eq_pkg::STEP_WRITE;
                    cbq_eq_pkg::STEP_WRITE:
                    begin
                        step_next = cbq_eq_pkg::STEP_READ;
                        if (band_reg == limit - BC_W'(1))
                            state_next = cbq_eq_pkg::ST_FINISH;
                        else
                            band_next = band_reg + BC_W'(1);
                    end
                    default: step_next = cbq_eq_pkg::STEP_READ;
                endcase
            end
            cbq_eq_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = cbq_eq_pkg::ST_IDLE;
                end
            end
            default: state_next = cbq_eq_pkg::ST_IDLE;
        endcase

        // Output slot: filled on load, drained when taken
        out_valid_next = cmd.load_out || (out_valid_reg && out_stall);
    end

endmodule

@@ src/cbq_eq_dp.sv @@
// Datapath of the equalizer: memories, shared multiplier, accumulators, output register.
module cbq_eq_dp #(
    parameter int MAX_BANDS      = 16,
    parameter int MAX_CHANNELS   = 8,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 26
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cbq_eq_pkg::cmd_t              cmd,
    input  logic [((MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1)-1:0] band,
    input  logic [2:0]                    channel,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic [3:0]                    coef_band,
    input  logic [2:0]                    coef_slot,
    input  logic signed [31:0]            coef_value,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic [2:0]                    channel_out,
    output logic                          clipped
);

    localparam int BI_W    = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int C_DEPTH = MAX_BANDS * cbq_eq_pkg::SLOTS;
    localparam int CA_W    = $clog2(C_DEPTH);
    localparam int D_DEPTH = MAX_BANDS * MAX_CHANNELS;
    localparam int DA_W    = (D_DEPTH > 1) ? $clog2(D_DEPTH) : 1;
    localparam int DB      = cbq_eq_pkg::DELAY_BITS;
    localparam int GB      = cbq_eq_pkg::GUARD_BITS;
    localparam int PW      = 32 + SAMPLE_BITS;
    localparam int R       = COEF_FRAC_BITS - GB;
    localparam int TW      = PW - R;
    localparam int ACC_W   = ((TW > DB) ? TW : DB) + 2;
    localparam int YF_W    = ACC_W - GB;
    localparam logic signed [31:0]    COEF_ONE = 32'sd1 <<< COEF_FRAC_BITS;
    localparam logic signed [PW-1:0]  P_RND    = {{(PW-1){1'b0}}, 1'b1} << (R - 1);
    localparam logic signed [ACC_W-1:0] Y_RND  = {{(ACC_W-1){1'b0}}, 1'b1} << (GB - 1);

    // Coefficient memory with per-entry valid (invalid reads as passthrough)
    logic [31:0]         coef_mem [C_DEPTH];
    logic [C_DEPTH-1:0]  coef_vld_reg;
    logic signed [31:0]  coef_q_reg;
    logic [7:0]          coef_waddr_full, coef_raddr_full;
    logic [CA_W-1:0]     coef_waddr, coef_raddr;
    logic [2:0]          rd_slot;
    logic                coef_we;

    // Delay memory, one row holds both delays of a band and channel
    logic [2*DB-1:0]     dly_mem [D_DEPTH];
    logic [D_DEPTH-1:0]  dly_vld_reg;
    logic [2*DB-1:0]     dly_q_reg;
    logic [9:0]          dly_addr_full;
    logic [DA_W-1:0]     dly_addr;
    logic                dly_we;

    // Working registers
    logic signed [SAMPLE_BITS-1:0] x_reg, y_reg, mul_op;
    logic [2:0]                    ch_reg;
    logic [CH_W-1:0]               chm_reg, chm;
    logic [4:0]                    ch_red;
    logic                          hit_reg;
    logic signed [PW-1:0]          prod_reg, prod_rnd;
    logic signed [ACC_W-1:0]       acc1_reg, acc2_reg;
    logic signed [ACC_W-1:0]       term_ext, z1_ext, z2_ext, wide_r, z2_sum;
    logic signed [YF_W-1:0]        y_full;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic                          y_fits;
    logic [DB-1:0]                 z1_new, z2_new;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic [2:0]                    out_ch_reg;
    logic                          out_clip_reg;

    // Saturate an accumulator to the delay width
    function automatic logic [DB-1:0] sat_delay(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-DB:0] top;
        top = v[ACC_W-1:DB-1];
        if ((&top) || !(|top))
            sat_delay = v[DB-1:0];
        else
            sat_delay = {v[ACC_W-1], {(DB-1){~v[ACC_W-1]}}};
    endfunction

    // Channel folded onto the delay channels
    always_comb
    begin
        ch_red = {2'b00, channel};
        for (int i = 0; i < 8; i++)
        begin
            if (ch_red >= 5'(MAX_CHANNELS))
                ch_red = ch_red - 5'(MAX_CHANNELS);
        end
        chm = ch_red[CH_W-1:0];
    end

    // Coefficient slot read at each step
    always_comb
    begin
        case (cmd.step)
            cbq_eq_pkg::STEP_READ:   rd_slot = cbq_eq_pkg::SLOT_B0;
            cbq_eq_pkg::STEP_MUL_B0: rd_slot = cbq_eq_pkg::SLOT_B1;
            cbq_eq_pkg::STEP_Y:      rd_slot = cbq_eq_pkg::SLOT_B2;
            cbq_eq_pkg::STEP_Z1A:    rd_slot = cbq_eq_pkg::SLOT_A1;
            cbq_eq_pkg::STEP_Z2A:    rd_slot = cbq_eq_pkg::SLOT_A2;
            default:                 rd_slot = cbq_eq_pkg::SLOT_B0;
        endcase
    end

    // Memory addresses
    assign coef_waddr_full = 8'(coef_band) * 8'(cbq_eq_pkg::SLOTS) + 8'(coef_slot);
    assign coef_raddr_full = 8'(band) * 8'(cbq_eq_pkg::SLOTS) + 8'(rd_slot);
    assign coef_waddr      = coef_waddr_full[CA_W-1:0];
    assign coef_raddr      = coef_raddr_full[CA_W-1:0];
    assign coef_we         = cmd.coef_write && (6'(coef_band) < 6'(MAX_BANDS))
                             && (coef_slot <= cbq_eq_pkg::SLOT_A2);
    assign dly_addr_full   = 10'(band) * 10'(MAX_CHANNELS) + 10'(chm_reg);
    assign dly_addr        = dly_addr_full[DA_W-1:0];
    assign dly_we          = cmd.band_active && (cmd.step == cbq_eq_pkg::STEP_WRITE);

    // Coefficient memory array
    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[coef_waddr] <= coef_value;
        coef_q_reg <= coef_vld_reg[coef_raddr] ? coef_mem[coef_raddr]
                    : ((rd_slot == cbq_eq_pkg::SLOT_B0) ? COEF_ONE : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coef_vld_reg <= '0;
        else if (coef_we)
            coef_vld_reg[coef_waddr] <= 1'b1;
    end

    // Delay memory array
    always_ff @(posedge clk)
    begin
        if (dly_we)
            dly_mem[dly_addr] <= {z2_new, z1_new};
        if (cmd.band_active && cmd.step == cbq_eq_pkg::STEP_READ)
            dly_q_reg <= dly_vld_reg[dly_addr] ? dly_mem[dly_addr] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dly_vld_reg <= '0;
        else if (dly_we)
            dly_vld_reg[dly_addr] <= 1'b1;
    end

    // Product rounding and operand alignment
    assign prod_rnd = prod_reg + P_RND;
    assign term_ext = {{(ACC_W-TW){prod_rnd[PW-1]}}, prod_rnd[PW-1:R]};
    assign z1_ext   = {{(ACC_W-DB){dly_q_reg[DB-1]}}, dly_q_reg[DB-1:0]};
    assign z2_ext   = {{(ACC_W-DB){dly_q_reg[2*DB-1]}}, dly_q_reg[2*DB-1:DB]};

    // Band output: round off guard bits, saturate to the sample range
    assign wide_r = term_ext + z1_ext + Y_RND;
    assign y_full = wide_r[ACC_W-1:GB];
    assign y_fits = (&y_full[YF_W-1:SAMPLE_BITS-1]) || !(|y_full[YF_W-1:SAMPLE_BITS-1]);
    assign y_sat  = y_fits ? y_full[SAMPLE_BITS-1:0]
                           : {y_full[YF_W-1], {(SAMPLE_BITS-1){~y_full[YF_W-1]}}};

    // New delays
    assign z2_sum = acc2_reg - term_ext;
    assign z1_new = sat_delay(acc1_reg);
    assign z2_new = sat_delay(z2_sum);

    // Feedforward terms use the band input, feedback terms the band output
    assign mul_op = (cmd.step == cbq_eq_pkg::STEP_Z2A || cmd.step == cbq_eq_pkg::STEP_Z1B)
                    ? y_reg : x_reg;

    // Shared multiplier and accumulators
    always_ff @(posedge clk)
    begin
        prod_reg <= coef_q_reg * mul_op;
        if (cmd.accept_sample)
        begin
            x_reg   <= sample_in;
            ch_reg  <= channel;
            chm_reg <= chm;
        end
        if (cmd.band_active)
        begin
            case (cmd.step)
                cbq_eq_pkg::STEP_Y:     y_reg    <= y_sat;
                cbq_eq_pkg::STEP_Z1A:   acc1_reg <= term_ext + z2_ext;
                cbq_eq_pkg::STEP_Z2A:   acc2_reg <= term_ext;
                cbq_eq_pkg::STEP_Z1B:   acc1_reg <= acc1_reg - term_ext;
                cbq_eq_pkg::STEP_WRITE: x_reg    <= y_reg;
                default: ;
            endcase
        end
        if (cmd.load_out)
        begin
            out_sample_reg <= x_reg;
            out_ch_reg     <= ch_reg;
            out_clip_reg   <= hit_reg;
        end
    end

    // Clip flag of the current sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else if (cmd.accept_sample)
            hit_reg <= 1'b0;
        else if (cmd.band_active && cmd.step == cbq_eq_pkg::STEP_Y && !y_fits)
            hit_reg <= 1'b1;
    end

    assign sample_out  = out_sample_reg;
    assign channel_out = out_ch_reg;
    assign clipped     = out_clip_reg;

endmodule
